### hw/rtl/sdalu_pkg.sv
// Package for the saturating decimal ALU: widths, op and status codes,
// scale and limit constants and the sideband struct of the pipeline.
// No dependencies.
`default_nettype none
package sdalu_pkg;

  // Decimal format
  localparam int FRACTION_DIGITS = 9;
  localparam int TOTAL_DIGITS    = 27;

  // Field widths
  localparam int HIGH_W = 27;
  localparam int LOW_W  = 64;
  localparam int MAG_W  = HIGH_W + LOW_W;  // operand width, also max magnitude width
  localparam int PROD_W = 2 * MAG_W;       // full product / dividend width
  localparam int CLAMP_W = MAG_W - 1;      // width of a clamped magnitude

  // Multiplier split
  localparam int LIMB_W   = 31;
  localparam int LIMBS    = (MAG_W + LIMB_W - 1) / LIMB_W;
  localparam int PP_W     = 2 * LIMB_W;
  localparam int COL_W    = PP_W + 2;
  localparam int NCOLS    = 2 * LIMBS - 1;
  localparam int SUM_W    = 2 * LIMBS * LIMB_W + 2;
  localparam int MUL_STAGES = 4;

  // Accept to result strobe, in cycles
  localparam int LATENCY = 1 + MUL_STAGES + PROD_W + 2;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_MOD = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVF      = 2'd1,
    ST_DIV_ZERO = 2'd2
  } status_e;

  // 10^n at product width
  function automatic logic [PROD_W-1:0] pow10(input int n);
    logic [PROD_W-1:0] p;
    p = PROD_W'(1);
    for (int i = 0; i < n; i++) begin
      p = p * PROD_W'(10);
    end
    return p;
  endfunction

  localparam logic [MAG_W-1:0]  SCALE = MAG_W'(pow10(FRACTION_DIGITS));
  localparam logic [PROD_W-1:0] LIMIT = pow10(TOTAL_DIGITS) - PROD_W'(1);

  // Item sideband that rides along the multiplier and divider
  typedef struct packed {
    op_e              op;
    logic             neg;
    logic             dzero;
    logic [MAG_W:0]   add_mag;
  } side_t;

endpackage
`default_nettype wire

### hw/rtl/saturating_decimal_alu_core.sv
// Top level of the saturating decimal ALU: operand decode, shared
// multiplier and divider, clamp and sign stages. Depends on sdalu_pkg,
// sdalu_mul and sdalu_div.
//
// Usage:
//   An item (op and two 91-bit scaled operands, given as a 27-bit signed
//   high word and a 64-bit low word) is accepted at a clock edge with start
//   high and busy low. busy is always low: the pipeline takes one item every
//   cycle with no dependence between items.
//   Each item yields one result on result_high_o, result_low_o and status_o,
//   shown for one cycle with done_o high. The receiver cannot stall.
//   Pipeline: 1 decode stage, 4 multiplier stages, 182 divider stages
//   (one quotient bit each, set by the 182-bit product width) and 2
//   clamp/sign stages.
//   All ops take the same path, so results leave in input order.
//   Throughput: one item per cycle.
//   Reset clears all valid bits; items in flight are dropped and done_o stays
//   low until new items arrive.
`default_nettype none
module saturating_decimal_alu_core import sdalu_pkg::*; (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               start,
  output logic              busy,
  input  wire [2:0]         op_i,
  input  wire [HIGH_W-1:0]  operand_a_high_i,
  input  wire [LOW_W-1:0]   operand_a_low_i,
  input  wire [HIGH_W-1:0]  operand_b_high_i,
  input  wire [LOW_W-1:0]   operand_b_low_i,
  output logic              done_o,
  output logic [HIGH_W-1:0] result_high_o,
  output logic [LOW_W-1:0]  result_low_o,
  output logic [1:0]        status_o
);

  logic [MAG_W-1:0] a_ext, b_ext, amag, bmag;
  logic             aneg, bneg;
  logic [MAG_W:0]   sum, sum_mag;
  op_e              op;

  logic [MAG_W-1:0] x_d, y_d, d_d, x_q, y_q, d_q;
  side_t            side_d, side_q;
  logic             vld_q;

  logic              mul_vld;
  logic [PROD_W-1:0] mul_prod;
  logic [MAG_W-1:0]  mul_d;
  side_t             mul_side;

  logic              div_vld;
  logic [PROD_W-1:0] div_quo;
  logic [MAG_W-1:0]  div_rem;
  side_t             div_side;

  logic [PROD_W-1:0] sel;
  logic [CLAMP_W-1:0] mag_d, mag_q;
  status_e           st_d, st_q;
  logic              neg_q, f1_vld_q;
  logic [MAG_W-1:0]  res;

  assign busy = 1'b0;
  assign op   = op_e'(op_i);

  // Decode: magnitudes, add/sub result, multiplier and divider operands
  always_comb begin
    a_ext = {operand_a_high_i, operand_a_low_i};
    b_ext = {operand_b_high_i, operand_b_low_i};
    aneg  = a_ext[MAG_W-1];
    bneg  = b_ext[MAG_W-1];
    amag  = aneg ? -a_ext : a_ext;
    bmag  = bneg ? -b_ext : b_ext;
    if (op == OP_SUB) begin
      sum = {a_ext[MAG_W-1], a_ext} - {b_ext[MAG_W-1], b_ext};
    end else begin
      sum = {a_ext[MAG_W-1], a_ext} + {b_ext[MAG_W-1], b_ext};
    end
    sum_mag = sum[MAG_W] ? -sum : sum;
    x_d = amag;
    case (op)
      OP_MUL: begin
        y_d = bmag;
        d_d = SCALE;
      end
      OP_DIV: begin
        y_d = SCALE;
        d_d = bmag;
      end
      default: begin
        y_d = MAG_W'(1);
        d_d = bmag;
      end
    endcase
    side_d.op      = op;
    side_d.dzero   = (bmag == '0);
    side_d.add_mag = sum_mag;
    case (op)
      OP_ADD, OP_SUB: side_d.neg = sum[MAG_W];
      OP_MOD:         side_d.neg = aneg;
      default:        side_d.neg = aneg ^ bneg;
    endcase
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    d_q    <= d_d;
    side_q <= side_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= start && !busy;
    end
  end

  sdalu_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld_q),
    .x_i     (x_q),
    .y_i     (y_q),
    .d_i     (d_q),
    .side_i  (side_q),
    .valid_o (mul_vld),
    .prod_o  (mul_prod),
    .d_o     (mul_d),
    .side_o  (mul_side)
  );

  sdalu_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mul_vld),
    .num_i   (mul_prod),
    .den_i   (mul_d),
    .side_i  (mul_side),
    .valid_o (div_vld),
    .quo_o   (div_quo),
    .rem_o   (div_rem),
    .side_o  (div_side)
  );

  // Clamp stage: pick the magnitude, saturate, flag divide by zero
  always_comb begin
    case (div_side.op)
      OP_ADD, OP_SUB: sel = PROD_W'(div_side.add_mag);
      OP_MUL, OP_DIV: sel = div_quo;
      OP_MOD:         sel = PROD_W'(div_rem);
      default:        sel = '0;
    endcase
    st_d  = ST_OK;
    mag_d = sel[CLAMP_W-1:0];
    if ((div_side.op == OP_DIV || div_side.op == OP_MOD) && div_side.dzero) begin
      st_d  = ST_DIV_ZERO;
      mag_d = '0;
    end else if (sel > LIMIT) begin
      st_d  = ST_OVF;
      mag_d = LIMIT[CLAMP_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    st_q  <= st_d;
    neg_q <= div_side.neg;
  end

  // Sign stage: apply sign, drive result registers
  assign res = neg_q ? -{1'b0, mag_q} : {1'b0, mag_q};

  always_ff @(posedge clk_i) begin
    result_high_o <= res[MAG_W-1:LOW_W];
    result_low_o  <= res[LOW_W-1:0];
    status_o      <= st_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_vld_q <= 1'b0;
      done_o   <= 1'b0;
    end else begin
      f1_vld_q <= div_vld;
      done_o   <= f1_vld_q;
    end
  end

  // Every accepted item comes out after the fixed latency
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##(LATENCY) done_o)
    else $error("accepted item did not produce a result");

  // No result without an accepted item
  a_no_spurious : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, LATENCY))
    else $error("result without an accepted item");

  // Divide by zero always returns zero
  a_dz_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_DIV_ZERO) |-> (result_low_o == '0 && result_high_o == '0))
    else $error("divide by zero result not zero");

  // Saturated result is never zero
  a_ovf_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_OVF) |-> (result_low_o != '0 || result_high_o != '0))
    else $error("saturated result is zero");

endmodule
`default_nettype wire

### hw/rtl/sdalu_mul.sv
// Four-stage unsigned magnitude multiplier built from 31x31 partial products.
// Depends on sdalu_pkg.
`default_nettype none
module sdalu_mul import sdalu_pkg::*; (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                valid_i,
  input  wire [MAG_W-1:0]    x_i,
  input  wire [MAG_W-1:0]    y_i,
  input  wire [MAG_W-1:0]    d_i,
  input  side_t              side_i,
  output logic               valid_o,
  output logic [PROD_W-1:0]  prod_o,
  output logic [MAG_W-1:0]   d_o,
  output side_t              side_o
);

  logic [LIMBS*LIMB_W-1:0] x_pad, y_pad;
  logic [PP_W-1:0]  pp_d  [LIMBS*LIMBS];
  logic [PP_W-1:0]  pp_q  [LIMBS*LIMBS];
  logic [COL_W-1:0] col_d [NCOLS];
  logic [COL_W-1:0] col_q [NCOLS];
  logic [SUM_W-1:0] even_d, odd_d, even_q, odd_q;
  logic [PROD_W-1:0] prod_d, prod_q;

  logic              vld_q  [MUL_STAGES];
  logic [MAG_W-1:0]  dd_q   [MUL_STAGES];
  side_t             side_q [MUL_STAGES];

  // Stage 1: partial products
  assign x_pad = (LIMBS*LIMB_W)'(x_i);
  assign y_pad = (LIMBS*LIMB_W)'(y_i);
  always_comb begin
    for (int i = 0; i < LIMBS; i++) begin
      for (int j = 0; j < LIMBS; j++) begin
        pp_d[i*LIMBS+j] = PP_W'(x_pad[i*LIMB_W +: LIMB_W]) * PP_W'(y_pad[j*LIMB_W +: LIMB_W]);
      end
    end
  end

  // Stage 2: column sums
  always_comb begin
    for (int k = 0; k < NCOLS; k++) begin
      col_d[k] = '0;
      for (int i = 0; i < LIMBS; i++) begin
        for (int j = 0; j < LIMBS; j++) begin
          if (i + j == k) begin
            col_d[k] = col_d[k] + COL_W'(pp_q[i*LIMBS+j]);
          end
        end
      end
    end
  end

  // Stage 3: even and odd columns
  always_comb begin
    even_d = '0;
    odd_d  = '0;
    for (int k = 0; k < NCOLS; k++) begin
      if (k % 2 == 0) begin
        even_d = even_d + (SUM_W'(col_q[k]) << (k * LIMB_W));
      end else begin
        odd_d = odd_d + (SUM_W'(col_q[k]) << (k * LIMB_W));
      end
    end
  end

  // Stage 4: final add
  assign prod_d = PROD_W'(even_q + odd_q);

  always_ff @(posedge clk_i) begin
    pp_q   <= pp_d;
    col_q  <= col_d;
    even_q <= even_d;
    odd_q  <= odd_d;
    prod_q <= prod_d;
    dd_q[0]   <= d_i;
    side_q[0] <= side_i;
    for (int s = 1; s < MUL_STAGES; s++) begin
      dd_q[s]   <= dd_q[s-1];
      side_q[s] <= side_q[s-1];
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < MUL_STAGES; s++) vld_q[s] <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
      for (int s = 1; s < MUL_STAGES; s++) vld_q[s] <= vld_q[s-1];
    end
  end

  assign valid_o = vld_q[MUL_STAGES-1];
  assign prod_o  = prod_q;
  assign d_o     = dd_q[MUL_STAGES-1];
  assign side_o  = side_q[MUL_STAGES-1];

endmodule
`default_nettype wire

### hw/rtl/sdalu_div.sv
// Fully pipelined restoring divider: one quotient bit per stage.
// Depends on sdalu_pkg.
`default_nettype none
module sdalu_div import sdalu_pkg::*; (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                valid_i,
  input  wire [PROD_W-1:0]   num_i,
  input  wire [MAG_W-1:0]    den_i,
  input  side_t              side_i,
  output logic               valid_o,
  output logic [PROD_W-1:0]  quo_o,
  output logic [MAG_W-1:0]   rem_o,
  output side_t              side_o
);

  // Index s is the input of stage s; s+1 its register
  logic [PROD_W-1:0] num_w  [PROD_W+1];
  logic [MAG_W-1:0]  rem_w  [PROD_W+1];
  logic [MAG_W-1:0]  den_w  [PROD_W+1];
  side_t             side_w [PROD_W+1];
  logic              vld_w  [PROD_W+1];

  assign num_w[0]  = num_i;
  assign rem_w[0]  = '0;
  assign den_w[0]  = den_i;
  assign side_w[0] = side_i;
  assign vld_w[0]  = valid_i;

  for (genvar s = 0; s < PROD_W; s++) begin : g_stage
    logic [MAG_W:0] rem_n;
    logic [MAG_W:0] diff;
    logic           ge;

    // Shift in next dividend bit, trial subtract
    assign rem_n = {rem_w[s], num_w[s][PROD_W-1]};
    assign diff  = rem_n - {1'b0, den_w[s]};
    assign ge    = rem_n >= {1'b0, den_w[s]};

    always_ff @(posedge clk_i) begin
      num_w[s+1]  <= {num_w[s][PROD_W-2:0], ge};
      rem_w[s+1]  <= ge ? diff[MAG_W-1:0] : rem_n[MAG_W-1:0];
      den_w[s+1]  <= den_w[s];
      side_w[s+1] <= side_w[s];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_w[s+1] <= 1'b0;
      end else begin
        vld_w[s+1] <= vld_w[s];
      end
    end
  end

  assign valid_o = vld_w[PROD_W];
  assign quo_o   = num_w[PROD_W];
  assign rem_o   = rem_w[PROD_W];
  assign side_o  = side_w[PROD_W];

endmodule
`default_nettype wire
